[sv/fla_pkg.sv]
// Package for the free-list allocator: field widths, reset constants, controller
// states and the result record. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fla_pkg;

	localparam int ADDR_W = 12;
	localparam int BYTES_W = 16;
	localparam int CFG_W = 13;
	localparam int NEED_W = 17;
	localparam int CMP_W = NEED_W + 2;

	localparam int ARENA_UNITS_DEF = 4096;
	localparam int UNIT_BYTES_DEF = 16;
	localparam logic [CFG_W-1:0] MIN_GROW_RESET = CFG_W'(1024);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_A0,
		ST_A1,
		ST_A2,
		ST_SPLIT,
		ST_F0,
		ST_F1,
		ST_I0,
		ST_I1,
		ST_I2,
		ST_I3,
		ST_I4,
		ST_I5,
		ST_I6,
		ST_DONE
	} fla_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_address;
		logic failed;
	} fla_res_t;

endpackage
`default_nettype wire

[sv/fla_if.sv]
// Request and response channel interfaces of the free-list allocator.
// Depends on fla_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fla_req_if
	import fla_pkg::*;
();
	logic valid;
	logic ready;
	logic operation;
	logic [BYTES_W-1:0] request_bytes;
	logic [ADDR_W-1:0] block_address;

	modport source (output valid, operation, request_bytes, block_address, input ready);
	modport sink (input valid, operation, request_bytes, block_address, output ready);
endinterface

interface fla_rsp_if
	import fla_pkg::*;
();
	logic valid;
	logic ready;
	logic [ADDR_W-1:0] payload_address;
	logic failed;

	modport source (output valid, payload_address, failed, input ready);
	modport sink (input valid, payload_address, failed, output ready);
endinterface
`default_nettype wire

[sv/fla_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/fla_ctrl.sv]
// Sequencer of the free-list allocator: size conversion, list walk, split,
// growth and address-ordered insertion over the header RAMs. Uses fla_pkg, fla_if.
`timescale 1ns / 1ps
`default_nettype none
module fla_ctrl
	import fla_pkg::*;
#(
	parameter int ARENA_UNITS = ARENA_UNITS_DEF,
	parameter int UNIT_BYTES = UNIT_BYTES_DEF,
	localparam int AW = $clog2(ARENA_UNITS),
	localparam int SW = AW + 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	fla_req_if.sink               req,
	input  wire logic [CFG_W-1:0] min_grow,
	output logic                  res_valid,
	output fla_res_t              res,
	input  wire logic             res_take,
	output logic                  link_we,
	output logic      [AW-1:0]    link_waddr,
	output logic      [AW-1:0]    link_wdata,
	output logic      [AW-1:0]    link_raddr,
	input  wire logic [AW-1:0]    link_rdata,
	output logic                  size_we,
	output logic      [AW-1:0]    size_waddr,
	output logic      [SW-1:0]    size_wdata,
	output logic      [AW-1:0]    size_raddr,
	input  wire logic [SW-1:0]    size_rdata
);
	localparam int NUM_W = NEED_W;
	localparam int DIV_SH = NUM_W + $clog2(UNIT_BYTES);
	localparam longint DIV_M = ((longint'(1) << DIV_SH) + UNIT_BYTES - 1) / UNIT_BYTES;
	localparam int PROD_W = NUM_W + DIV_SH;
	localparam logic [DIV_SH-1:0] DIV_M_V = DIV_SH'(DIV_M);
	localparam int WALK_LIMIT = 2 * ARENA_UNITS + 4;
	localparam int CNT_W = $clog2(WALK_LIMIT + 1);
	localparam logic [CNT_W-1:0] LIMIT_V = CNT_W'(WALK_LIMIT);
	localparam logic [CMP_W-1:0] TOP_V = CMP_W'(ARENA_UNITS - 1);

	fla_state_t state_q, state_d;

	logic started_q;
	logic [AW-1:0] fs_q;
	logic [AW-1:0] brk_q;
	logic [CNT_W-1:0] acnt_q;
	logic [CNT_W-1:0] icnt_q;

	logic op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PROD_W-1:0] prod_s1;
	logic [NEED_W-1:0] need_q;
	logic [AW-1:0] prev_q, p_q, q_q, nx_q, bp_q, lknx_q, lkbp2_q;
	logic [SW-1:0] szbp_q, sznx_q, szp_q, szbp2_q;
	logic down_q;
	fla_res_t res_q;

	logic accept;
	logic [NUM_W-1:0] bytes_up;
	logic fit, exact, at_fs, grow_bad, alim, ilim, found, free_ok, size_ok;
	logic up;
	logic [SW-1:0] newsz, szbp2;
	logic [AW-1:0] lkbp2;
	logic [CMP_W-1:0] grow, brk_w, h_w;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res = res_q;
	assign bytes_up = NUM_W'(req.request_bytes) + NUM_W'(UNIT_BYTES - 1);

	always_comb begin
		brk_w = CMP_W'(brk_q);
		fit = CMP_W'(size_rdata) >= CMP_W'(need_q);
		exact = CMP_W'(size_rdata) == CMP_W'(need_q);
		newsz = size_rdata - SW'(need_q);
		at_fs = (p_q == fs_q);
		grow = (CMP_W'(need_q) < CMP_W'(min_grow)) ? CMP_W'(min_grow) : CMP_W'(need_q);
		grow_bad = (brk_w > TOP_V) || (grow > TOP_V - brk_w);
		alim = (acnt_q == LIMIT_V);
		ilim = (icnt_q == LIMIT_V);
		found = (bp_q > p_q && bp_q < link_rdata) ||
			(p_q >= link_rdata && (bp_q > p_q || bp_q < link_rdata));
		h_w = CMP_W'(addr_q) - CMP_W'(1);
		free_ok = (addr_q >= ADDR_W'(2)) && (h_w < brk_w);
		size_ok = (size_rdata != '0) &&
			(CMP_W'(size_rdata) <= brk_w - CMP_W'(bp_q));
		up = (CMP_W'(bp_q) + CMP_W'(szbp_q)) == CMP_W'(nx_q);
		szbp2 = up ? SW'(szbp_q + sznx_q) : szbp_q;
		lkbp2 = up ? lknx_q : nx_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SETUP;
			ST_SETUP: state_d = (op_q == OP_ALLOC) ? ST_A0 : ST_F0;
			ST_A0:    state_d = ST_A1;
			ST_A1:    state_d = ST_A2;
			ST_A2: begin
				priority if (alim) state_d = ST_DONE;
				else if (fit) state_d = exact ? ST_DONE : ST_SPLIT;
				else if (at_fs) state_d = grow_bad ? ST_DONE : ST_I0;
				else state_d = ST_A2;
			end
			ST_SPLIT: state_d = ST_DONE;
			ST_F0:    state_d = free_ok ? ST_F1 : ST_DONE;
			ST_F1:    state_d = size_ok ? ST_I0 : ST_DONE;
			ST_I0:    state_d = ST_I1;
			ST_I1: begin
				priority if (ilim) state_d = ST_DONE;
				else if (found) state_d = ST_I2;
				else state_d = ST_I1;
			end
			ST_I2:    state_d = ST_I3;
			ST_I3:    state_d = ST_I4;
			ST_I4:    state_d = ST_I5;
			ST_I5:    state_d = ST_I6;
			ST_I6:    state_d = (op_q == OP_ALLOC) ? ST_A0 : ST_DONE;
			ST_DONE:  if (res_take) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM controls.
	always_comb begin
		link_we = 1'b0;
		link_waddr = p_q;
		link_wdata = bp_q;
		link_raddr = fs_q;
		size_we = 1'b0;
		size_waddr = p_q;
		size_wdata = newsz;
		size_raddr = p_q;
		unique case (state_q)
			ST_SETUP: begin
				link_we = !started_q;
				link_waddr = '0;
				link_wdata = '0;
				size_we = !started_q;
				size_waddr = '0;
				size_wdata = '0;
			end
			ST_A0: link_raddr = fs_q;
			ST_A1: begin
				link_raddr = link_rdata;
				size_raddr = link_rdata;
			end
			ST_A2: begin
				link_raddr = link_rdata;
				size_raddr = link_rdata;
				if (!alim && fit && exact) begin
					link_we = 1'b1;
					link_waddr = prev_q;
					link_wdata = link_rdata;
				end else if (!alim && fit) begin
					size_we = 1'b1;
					size_waddr = p_q;
					size_wdata = newsz;
				end else if (!alim && at_fs && !grow_bad) begin
					size_we = 1'b1;
					size_waddr = brk_q;
					size_wdata = SW'(grow);
				end
			end
			ST_SPLIT: begin
				size_we = 1'b1;
				size_waddr = q_q;
				size_wdata = SW'(need_q);
			end
			ST_F0: size_raddr = AW'(h_w);
			ST_I0: link_raddr = fs_q;
			ST_I1: link_raddr = link_rdata;
			ST_I2: begin
				size_raddr = bp_q;
				link_raddr = nx_q;
			end
			ST_I3: size_raddr = nx_q;
			ST_I4: size_raddr = p_q;
			ST_I5: begin
				size_we = 1'b1;
				size_waddr = bp_q;
				size_wdata = szbp2;
				link_we = 1'b1;
				link_waddr = bp_q;
				link_wdata = lkbp2;
			end
			ST_I6: begin
				link_we = 1'b1;
				link_waddr = p_q;
				link_wdata = down_q ? lkbp2_q : bp_q;
				size_we = down_q;
				size_waddr = p_q;
				size_wdata = SW'(szp_q + szbp2_q);
			end
			default: ;
		endcase
	end

	// Allocator state and walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			fs_q <= '0;
			brk_q <= AW'(1);
			acnt_q <= '0;
			icnt_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_SETUP: begin
					started_q <= 1'b1;
					if (!started_q) fs_q <= '0;
					acnt_q <= '0;
				end
				ST_A2: begin
					acnt_q <= acnt_q + CNT_W'(1);
					if (!alim && fit) fs_q <= prev_q;
					else if (!alim && at_fs && !grow_bad) brk_q <= AW'(brk_w + grow);
				end
				ST_I0: icnt_q <= '0;
				ST_I1: icnt_q <= icnt_q + CNT_W'(1);
				ST_I6: fs_q <= p_q;
				default: ;
			endcase
		end
	end

	// Walk registers and result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q <= req.operation;
				addr_q <= req.block_address;
				prod_s1 <= PROD_W'(bytes_up) * PROD_W'(DIV_M_V);
			end
			ST_SETUP: begin
				need_q <= prod_s1[PROD_W-1:DIV_SH] + NEED_W'(1);
				res_q <= '0;
			end
			ST_A0: prev_q <= fs_q;
			ST_A1: p_q <= link_rdata;
			ST_A2: begin
				priority if (alim) begin
					res_q.failed <= 1'b1;
				end else if (fit && exact) begin
					res_q.payload_address <= ADDR_W'(CMP_W'(p_q) + CMP_W'(1));
				end else if (fit) begin
					q_q <= AW'(CMP_W'(p_q) + CMP_W'(newsz));
					res_q.payload_address <=
						ADDR_W'(CMP_W'(p_q) + CMP_W'(newsz) + CMP_W'(1));
				end else if (at_fs) begin
					if (grow_bad) res_q.failed <= 1'b1;
					bp_q <= brk_q;
				end else begin
					prev_q <= p_q;
					p_q <= link_rdata;
				end
			end
			ST_F0: bp_q <= AW'(h_w);
			ST_I0: p_q <= fs_q;
			ST_I1: begin
				priority if (ilim) begin
					if (op_q == OP_ALLOC) res_q.failed <= 1'b1;
				end else if (found) begin
					nx_q <= link_rdata;
				end else begin
					p_q <= link_rdata;
				end
			end
			ST_I3: begin
				szbp_q <= size_rdata;
				lknx_q <= link_rdata;
			end
			ST_I4: sznx_q <= size_rdata;
			ST_I5: begin
				szp_q <= size_rdata;
				szbp2_q <= szbp2;
				lkbp2_q <= lkbp2;
				down_q <= (CMP_W'(p_q) + CMP_W'(size_rdata)) == CMP_W'(bp_q);
			end
			default: ;
		endcase
	end

	a_brk_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> brk_q >= $past(brk_q))
		else $error("arena break moved down");
	a_brk_top: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(brk_q) <= TOP_V)
		else $error("arena break passed the top unit");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.failed |-> res.payload_address == '0)
		else $error("failed allocate carries an address");
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP |=> started_q)
		else $error("sentinel not set up after first request");
endmodule
`default_nettype wire

[sv/free_list_allocator_unit.sv]
// Top level of the free-list allocator: configuration register, header RAMs,
// sequencer and response register. Uses fla_pkg, fla_if, fla_ram, fla_ctrl.
//
//   Channel   Kind               Contents
//   req       valid/ready sink   operation, request_bytes, block_address
//   rsp       valid/ready source payload_address, failed
//   cfg       write enable       cfg_wdata -> min_grow
//
// An allocate runs from acceptance through setup and a walk of the free list,
// with a split step added when a larger block is split, to a valid response.
// Each growth adds an address-ordered search and header updates, then re-walks.
// A free runs that search and the header updates; an ignored free ends after
// its header checks. The walk is paced by the registered RAM reads.
// Reset sets the break to unit 1 and clears the free-list start and the sentinel
// flag; the header RAMs need no clearing, since the sentinel is written by the
// first request. The response register holds a result until rsp.ready, and the
// next request is taken in the cycle after the result moves into that register.
`timescale 1ns / 1ps
`default_nettype none
module free_list_allocator_unit
	import fla_pkg::*;
#(
	parameter int ARENA_UNITS = ARENA_UNITS_DEF,
	parameter int UNIT_BYTES = UNIT_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	fla_req_if.sink               req,
	fla_rsp_if.source             rsp,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);
	localparam int AW = $clog2(ARENA_UNITS);
	localparam int SW = AW + 1;

	logic [CFG_W-1:0] min_grow_q;
	logic rsp_valid_q;
	fla_res_t rsp_q;

	logic res_valid, res_take;
	fla_res_t res;
	logic link_we, size_we;
	logic [AW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
	logic [AW-1:0] size_waddr, size_raddr;
	logic [SW-1:0] size_wdata, size_rdata;

	// Write the growth register only while no request is in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_grow_q <= MIN_GROW_RESET;
		end else if (cfg_we) begin
			min_grow_q <= cfg_wdata;
		end
	end

	// The result leaves the sequencer when the response register is empty or
	// being drained in the same cycle.
	assign res_take = res_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.payload_address = rsp_q.payload_address;
	assign rsp.failed = rsp_q.failed;

	// Header link and size of every unit live in two RAMs addressed by unit.
	fla_ram #(.WIDTH(AW), .DEPTH(ARENA_UNITS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	fla_ram #(.WIDTH(SW), .DEPTH(ARENA_UNITS)) u_size_ram (
		.clk   (clk),
		.we    (size_we),
		.waddr (size_waddr),
		.wdata (size_wdata),
		.raddr (size_raddr),
		.rdata (size_rdata)
	);

	fla_ctrl #(.ARENA_UNITS(ARENA_UNITS), .UNIT_BYTES(UNIT_BYTES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.min_grow   (min_grow_q),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_raddr (link_raddr),
		.link_rdata (link_rdata),
		.size_we    (size_we),
		.size_waddr (size_waddr),
		.size_wdata (size_wdata),
		.size_raddr (size_raddr),
		.size_rdata (size_rdata)
	);
endmodule
`default_nettype wire
